// ----- hdl/md5_pkg.sv -----
// Shared types, constants and round tables of the MD5 digest block.
`timescale 1ns / 1ps

package md5_pkg;

    // Initial chaining values A, B, C, D
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Padding marker byte
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Controller to datapath commands
    typedef struct packed {
        logic       wr_byte;    // store the input byte, count it
        logic       pad;        // store the marker byte, clear the rest of the block
        logic       len;        // store the bit length in words 14 and 15
        logic       len_clear;  // clear the whole block before the length goes in
        logic       round;      // run one compression round
        logic [5:0] rnd;        // round number
        logic       fold;       // add the working words into the chaining words
        logic       emit;       // load the digest register, restart the message
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [5:0] pos;        // byte position within the current block
        logic       out_busy;   // digest register full and not taken this cycle
    } t_dp_stat;

    // Additive round constant
    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left rotate amount, picked by round group and round number modulo four
    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word index used by a round
    function automatic logic [3:0] round_g(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = i[3:0] * 4'd5 + 4'd1;
            2'd2: g = i[3:0] * 4'd3 + 4'd5;
            2'd3: g = i[3:0] * 4'd7;
            default: g = 4'd0;
        endcase
        return g;
    endfunction

endpackage

// ----- hdl/md5_ctrl.sv -----
// Sequencer of the MD5 digest block: byte intake, padding, rounds and digest hand-off.
`timescale 1ns / 1ps

module md5_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_s_tuser,
    input  logic              i_s_tlast,
    input  md5_pkg::t_dp_stat i_stat,
    output md5_pkg::t_dp_cmd  o_cmd
);
    import md5_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_FOLD  = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // Which block the running compression belongs to
    localparam logic [1:0] PH_DATA  = 2'd0;
    localparam logic [1:0] PH_EXTRA = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    logic [2:0] r_state, n_state;
    logic [5:0] r_rnd,   n_rnd;
    logic [1:0] r_phase, n_phase;
    logic       r_fin,   n_fin;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid & o_s_tready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_phase = r_phase;
        n_fin   = r_fin;
        o_cmd   = '0;
        o_cmd.rnd = r_rnd;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.wr_byte = i_s_tuser;
                    if (i_s_tuser && i_stat.pos == 6'd63) begin
                        n_state = S_ROUND;
                        n_phase = PH_DATA;
                        n_fin   = i_s_tlast;
                    end else if (i_s_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                unique case (r_phase)
                    PH_DATA:  n_state = r_fin ? S_PAD : S_IDLE;
                    PH_EXTRA: n_state = S_LEN;
                    PH_FINAL: n_state = S_OUT;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_PAD: begin
                o_cmd.pad = 1'b1;
                // no room left for the length: run this block first
                if (i_stat.pos[5:3] == 3'b111) begin
                    n_state = S_ROUND;
                    n_phase = PH_EXTRA;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.len       = 1'b1;
                o_cmd.len_clear = (r_phase == PH_EXTRA);
                n_state = S_ROUND;
                n_phase = PH_FINAL;
            end
            S_OUT: begin
                // hold until the digest register is free
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= 6'd0;
            r_phase <= PH_DATA;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_phase <= n_phase;
            r_fin   <= n_fin;
        end
    end

endmodule

// ----- hdl/md5_dp.sv -----
// Datapath of the MD5 digest block: message block, round unit, chaining words, digest register.
`timescale 1ns / 1ps

module md5_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  md5_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]        i_byte,
    input  logic              i_m_tready,
    output md5_pkg::t_dp_stat o_stat,
    output logic              o_m_tvalid,
    output logic [127:0]      o_m_tdata
);
    import md5_pkg::*;

    logic [31:0]  r_blk [16];
    logic [31:0]  n_blk [16];
    logic [31:0]  r_h   [4];
    logic [31:0]  r_w   [4];
    logic [60:0]  r_cnt;
    logic         r_ovalid;
    logic [127:0] r_odata;

    logic [63:0]  w_bits;
    logic [31:0]  w_a, w_b, w_c, w_d, w_f, w_sum, w_nb;

    // Keep the bytes below the lane, set the lane, clear the bytes above it
    function automatic logic [31:0] merge(input logic [31:0] old, input logic [7:0] v,
                                          input logic [1:0] lane);
        logic [31:0] res;
        unique case (lane)
            2'd0: res = {24'h0, v};
            2'd1: res = {16'h0, v, old[7:0]};
            2'd2: res = {8'h0, v, old[15:0]};
            2'd3: res = {v, old[23:0]};
            default: res = old;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    assign w_bits          = {r_cnt, 3'b000};
    assign o_stat.pos      = r_cnt[5:0];
    assign o_stat.out_busy = r_ovalid & ~i_m_tready;
    assign o_m_tvalid      = r_ovalid;
    assign o_m_tdata       = r_odata;

    // Next message block contents
    always_comb begin
        for (int w = 0; w < 16; w++) begin
            n_blk[w] = r_blk[w];
            if (i_cmd.len_clear) begin
                n_blk[w] = 32'h0;
            end
            if (i_cmd.wr_byte && r_cnt[5:2] == 4'(w)) begin
                n_blk[w] = merge(r_blk[w], i_byte, r_cnt[1:0]);
            end
            if (i_cmd.pad) begin
                if (r_cnt[5:2] == 4'(w)) begin
                    n_blk[w] = merge(r_blk[w], PAD_BYTE, r_cnt[1:0]);
                end else if (r_cnt[5:2] < 4'(w)) begin
                    n_blk[w] = 32'h0;
                end
            end
        end
        if (i_cmd.len) begin
            n_blk[14] = w_bits[31:0];
            n_blk[15] = w_bits[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < 16; w++) begin
            r_blk[w] <= n_blk[w];
        end
    end

    // Round unit: round zero starts from the chaining words
    assign w_a = (i_cmd.rnd == 6'd0) ? r_h[0] : r_w[0];
    assign w_b = (i_cmd.rnd == 6'd0) ? r_h[1] : r_w[1];
    assign w_c = (i_cmd.rnd == 6'd0) ? r_h[2] : r_w[2];
    assign w_d = (i_cmd.rnd == 6'd0) ? r_h[3] : r_w[3];

    always_comb begin
        unique case (i_cmd.rnd[5:4])
            2'd0: w_f = (w_b & w_c) | (~w_b & w_d);
            2'd1: w_f = (w_d & w_b) | (~w_d & w_c);
            2'd2: w_f = w_b ^ w_c ^ w_d;
            2'd3: w_f = w_c ^ (w_b | ~w_d);
            default: w_f = 32'h0;
        endcase
    end

    assign w_sum = w_a + w_f + round_k(i_cmd.rnd) + r_blk[round_g(i_cmd.rnd)];
    assign w_nb  = w_b + rotl(w_sum, round_s(i_cmd.rnd));

    // Advance the working words one round
    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            r_w[0] <= w_d;
            r_w[1] <= w_nb;
            r_w[2] <= w_b;
            r_w[3] <= w_c;
        end
    end

    // Chaining words and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0] <= IV_A;
            r_h[1] <= IV_B;
            r_h[2] <= IV_C;
            r_h[3] <= IV_D;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.emit) begin
                r_h[0] <= IV_A;
                r_h[1] <= IV_B;
                r_h[2] <= IV_C;
                r_h[3] <= IV_D;
                r_cnt  <= '0;
            end else begin
                if (i_cmd.fold) begin
                    for (int k = 0; k < 4; k++) begin
                        r_h[k] <= r_h[k] + r_w[k];
                    end
                end
                if (i_cmd.wr_byte) begin
                    r_cnt <= r_cnt + 61'd1;
                end
            end
        end
    end

    // Digest register: hold until transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= {swap32(r_h[2]), swap32(r_h[3]), swap32(r_h[0]), swap32(r_h[1])};
        end
    end

endmodule

// ----- hdl/md5_message_digest.sv -----
// Top level of the MD5 digest block: controller and datapath.
`timescale 1ns / 1ps
// MD5 message digest over a byte stream.
// Slave channel: one transfer per message byte. tdata carries the byte, tuser
// says whether the byte is present, tlast ends the message (it may carry no byte,
// so an empty message is a single transfer with tuser low and tlast high).
// Master channel: one transfer per message, the 16-byte digest.
// Throughput: one byte per cycle while ready is high; every 64th byte holds ready
// low for the 64 rounds, one per cycle, and then the chaining update. The single
// round unit sets this.
// After tlast the sequencer pads, stores the length, runs the final rounds and
// chaining update, then loads the digest register; a padded block with no room for
// the length runs first, and so does a block that the tlast transfer filled.
// The digest sits in an output register; the slave channel accepts the next
// message while it waits. If the receiver stalls, a second digest waits in the
// chaining words and the slave channel holds ready low until the first is taken.
// Reset (synchronous, active low) loads the initial chaining values, clears the
// byte count and empties the output register; the block is ready at once.
module md5_message_digest (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  logic         i_s_tuser,   // [0] byte_present
    input  logic         i_s_tlast,   // last_byte
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata    // [63:0] digest_head, [127:64] digest_tail
);
    import md5_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    md5_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    md5_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_byte     (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ----- tb/tb_md5_message_digest.sv -----
// Self-checking testbench for the MD5 byte-stream digest block.
`timescale 1ns / 1ps

module tb_md5_message_digest;

    import md5_pkg::*;

    localparam int RAND_ITEMS     = 1880;
    localparam int STALL_LIMIT    = 10000;
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int PAUSE_AT_MSG   = 20;

    // Per-step additive constants and rotate amounts of the compression
    localparam logic [31:0] STEP_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int STEP_ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                     4, 11, 16, 23, 6, 10, 15, 21};

    // One row of the directed stimulus; head and tail are used when known is set
    typedef struct packed {
        logic [7:0]  data;
        logic        present;
        logic        last;
        logic        known;
        logic [63:0] head;
        logic [63:0] tail;
    } t_stim_row;

    localparam int DIR_ROWS = 16;
    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        // empty message
        '{8'h00, 1'b0, 1'b1, 1'b1, 64'hd41d8cd98f00b204, 64'he9800998ecf8427e},
        // "a" in a single transfer
        '{8'h61, 1'b1, 1'b1, 1'b1, 64'h0cc175b9c0f1b6a8, 64'h31c399e269772661},
        // "abc"
        '{8'h61, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, 64'h900150983cd24fb0, 64'hd6963f7d28e17f72},
        // no byte and not last: nothing happens
        '{8'ha5, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'hff, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        // "a" with an empty transfer inside, closed by a bare last
        '{8'h61, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h5a, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'hff, 1'b0, 1'b1, 1'b1, 64'h0cc175b9c0f1b6a8, 64'h31c399e269772661},
        // second empty message straight after, stray data ignored
        '{8'hff, 1'b0, 1'b1, 1'b1, 64'hd41d8cd98f00b204, 64'he9800998ecf8427e},
        // extreme byte values
        '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h80, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0}
    };

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;   // [7:0] data_byte
    logic         s_tuser  = 1'b0;    // [0] byte_present
    logic         s_tlast  = 1'b0;    // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;            // [63:0] digest_head, [127:64] digest_tail

    // Digest predictor state
    logic [31:0] hash_state [4];
    logic [31:0] msg_words [16];
    logic [60:0] msg_len_bytes;

    logic [127:0] digest_q [$];
    logic [127:0] digest_want;
    int           mismatch_count = 0;
    int           digest_count   = 0;
    int           items_sent     = 0;
    int           idle_cycles    = 0;
    bit           tx_burst       = 1'b0;
    bit           rx_burst       = 1'b0;
    bit           rx_long_hold   = 1'b0;

    md5_message_digest u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] byte_swap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Restart the digest at the initial chaining values
    task automatic digest_model_clear();
        int k;
        hash_state[0] = IV_A;
        hash_state[1] = IV_B;
        hash_state[2] = IV_C;
        hash_state[3] = IV_D;
        for (k = 0; k < 16; k++) msg_words[k] = '0;
        msg_len_bytes = '0;
    endtask

    // Fold the current 16-word block into the chaining words
    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, t;
        int i, g;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        for (i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t = d;
            d = c;
            c = b;
            b = b + rotl32(a + f + STEP_ADD[i] + msg_words[g], STEP_ROT[(i / 16) * 4 + i % 4]);
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
    endtask

    // Place a byte little-endian; the first byte of a word clears it
    task automatic store_byte(input int pos, input logic [7:0] v);
        if (pos % 4 == 0) msg_words[pos / 4] = '0;
        msg_words[pos / 4][(pos % 4) * 8 +: 8] = v;
    endtask

    // Advance the predictor by one accepted transfer
    task automatic digest_model_step(input logic [7:0] b, input logic present, input logic last,
                                     output logic done, output logic [127:0] dig);
        int pos, k;
        logic [63:0] bit_len;
        done = 1'b0;
        dig  = '0;
        if (present) begin
            pos = int'(msg_len_bytes[5:0]);
            store_byte(pos, b);
            msg_len_bytes = msg_len_bytes + 61'd1;
            if (pos == 63) md5_compress();
        end
        if (last) begin
            // pad with the marker and zeros, spilling into a second block if needed
            pos = int'(msg_len_bytes[5:0]);
            store_byte(pos, PAD_BYTE);
            for (k = pos + 1; k < 64; k++) store_byte(k, 8'h00);
            if (pos >= 56) begin
                md5_compress();
                for (k = 0; k < 16; k++) msg_words[k] = '0;
            end
            bit_len = {msg_len_bytes, 3'b000};
            msg_words[14] = bit_len[31:0];
            msg_words[15] = bit_len[63:32];
            md5_compress();
            dig = {byte_swap(hash_state[2]), byte_swap(hash_state[3]),
                   byte_swap(hash_state[0]), byte_swap(hash_state[1])};
            done = 1'b1;
            digest_model_clear();
        end
    endtask

    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(input logic [7:0] b, input logic present, input logic last,
                             input logic known, input logic [127:0] typed_dig);
        int gap;
        logic done;
        logic [127:0] dig;
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        digest_model_step(b, present, last, done, dig);
        if (done) digest_q = {digest_q, (known ? typed_dig : dig)};
        if (present || last) items_sent++;
    endtask

    // Drop valid and hold the sender until every digest has come out
    task automatic drain_digests();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (digest_q.size() != 0);
    endtask

    // Receiver: random ready gaps, bursts, and one long hold-off
    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 9);
            if (rx_long_hold) begin
                gap = RX_HOLD_CYCLES;
                rx_long_hold = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    // Compare each digest transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                digest_want = digest_q.pop_front();
                digest_count++;
                if (m_tdata[63:0] !== digest_want[63:0]) begin
                    $display("%0t: digest_head expected %h got %h",
                             $time, digest_want[63:0], m_tdata[63:0]);
                    mismatch_count++;
                end
                if (m_tdata[127:64] !== digest_want[127:64]) begin
                    $display("%0t: digest_tail expected %h got %h",
                             $time, digest_want[127:64], m_tdata[127:64]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int r, len, k, msg_index;
        logic carry_last;
        digest_model_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (r = 0; r < DIR_ROWS; r++) begin
            send_item(DIR_TABLE[r].data, DIR_TABLE[r].present, DIR_TABLE[r].last,
                      DIR_TABLE[r].known, {DIR_TABLE[r].tail, DIR_TABLE[r].head});
        end
        drain_digests();

        // random messages; the receiver stalls hard near the start
        rx_long_hold = 1'b1;
        msg_index = 0;
        while (items_sent < DIR_ROWS + RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(0, 20);
                4, 5:       len = $urandom_range(52, 72);
                6, 7:       len = $urandom_range(110, 135);
                8:          len = $urandom_range(0, 63);
                default:    len = $urandom_range(128, 200);
            endcase
            carry_last = (len > 0) && ($urandom_range(0, 1) == 1);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                send_item(8'($urandom_range(0, 255)), 1'b1, carry_last && (k == len - 1),
                          1'b0, '0);
            end
            if (!carry_last) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
            msg_index++;
            if (msg_index == PAUSE_AT_MSG) drain_digests();
        end

        // wait out the remaining digests and the pipeline
        drain_digests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- md5_message_digest.f -----
hdl/md5_pkg.sv
hdl/md5_ctrl.sv
hdl/md5_dp.sv
hdl/md5_message_digest.sv
tb/tb_md5_message_digest.sv
